FILE: src/lcd_mode_and_line_timing_core_macros.svh
// Assertion macros shared by the LCD timing block.
`ifndef LCD_MODE_AND_LINE_TIMING_CORE_MACROS_SVH
`define LCD_MODE_AND_LINE_TIMING_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during rst.
`define LMLT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off during rst.
`define LMLT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/lmlt_pkg.sv
// Package with the codes, constants and result type of the LCD timing block.
package lmlt_pkg;

  localparam int LINE_CYCLES_DEFAULT   = 456;
  localparam int FRAME_CYCLES_DEFAULT  = 70224;
  localparam int VBLANK_START_DEFAULT  = 65664;
  localparam int VISIBLE_LINES_DEFAULT = 144;

  localparam int CYCLES_W    = 8;
  localparam int LINE_W      = 8;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_INDEX_W = 1;

  // Cycle thresholds within one line.
  localparam int XFER_START   = 80;
  localparam int HBLANK_START = 356;
  localparam int RENDER_AFTER = 83;

  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_LINE_COMPARE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IRQ_ENABLE   = 1'd1;

  typedef struct packed {
    logic [1:0]        lcd_mode;
    logic [LINE_W-1:0] current_line;
    logic              coincidence;
    logic              render_line;
    logic              stat_irq;
    logic              vblank_irq;
  } lmlt_result_t;

endpackage

FILE: src/lmlt_step.sv
// Next-state and result logic for one cycle-count transaction.
module lmlt_step #(
  parameter int LINE_CYCLES   = lmlt_pkg::LINE_CYCLES_DEFAULT,
  parameter int FRAME_CYCLES  = lmlt_pkg::FRAME_CYCLES_DEFAULT,
  parameter int VBLANK_START  = lmlt_pkg::VBLANK_START_DEFAULT,
  parameter int VISIBLE_LINES = lmlt_pkg::VISIBLE_LINES_DEFAULT,
  localparam int FP_W   = $clog2(FRAME_CYCLES),
  localparam int INTO_W = $clog2(LINE_CYCLES)
) (
  input  logic [lmlt_pkg::CYCLES_W-1:0] cycles,
  input  logic [FP_W-1:0]               frame_position,
  input  logic [INTO_W-1:0]             line_offset,
  input  logic [lmlt_pkg::LINE_W-1:0]   line,
  input  logic [lmlt_pkg::LINE_W-1:0]   rendered_line,
  input  logic [lmlt_pkg::LINE_W-1:0]   last_line,
  input  logic                          coincidence_flag,
  input  logic [lmlt_pkg::LINE_W-1:0]   line_compare,
  input  logic                          coincidence_irq_enable,
  output logic [FP_W-1:0]               frame_position_next,
  output logic [INTO_W-1:0]             line_offset_next,
  output logic [lmlt_pkg::LINE_W-1:0]   rendered_line_next,
  output logic [lmlt_pkg::LINE_W-1:0]   last_line_next,
  output logic                          coincidence_flag_next,
  output lmlt_pkg::lmlt_result_t        result
);

  localparam int POS_W = $clog2(FRAME_CYCLES + 256);
  localparam int SUM_W = $clog2(LINE_CYCLES + 256);
  // Most line boundaries one transaction can cross.
  localparam int MAX_CROSS = (LINE_CYCLES + 254) / LINE_CYCLES;

  logic [POS_W-1:0]            sum;
  logic                        wrap;
  logic [POS_W-1:0]            pos;
  logic [SUM_W-1:0]            offset;
  logic [lmlt_pkg::LINE_W-1:0] line_now;
  logic                        render_hit;
  logic [1:0]                  mode;

  // The line and the offset into it are tracked incrementally, so the
  // division by the line length becomes MAX_CROSS compare-and-subtract steps.
  always_comb begin
    sum  = POS_W'(frame_position) + POS_W'(cycles);
    wrap = (sum >= POS_W'(FRAME_CYCLES));
    pos  = wrap ? (sum - POS_W'(FRAME_CYCLES)) : sum;
    if (wrap) begin
      offset   = SUM_W'(pos);
      line_now = '0;
    end else begin
      offset   = SUM_W'(line_offset) + SUM_W'(cycles);
      line_now = line;
    end
    for (int k = 0; k < MAX_CROSS; k++) begin
      if (offset >= SUM_W'(LINE_CYCLES)) begin
        offset   = offset - SUM_W'(LINE_CYCLES);
        line_now = line_now + lmlt_pkg::LINE_W'(1);
      end
    end
  end

  assign frame_position_next = FP_W'(pos);
  assign line_offset_next    = INTO_W'(offset);

  always_comb begin
    if (32'(pos) >= 32'(VBLANK_START)) begin
      mode = lmlt_pkg::MODE_VBLANK;
    end else if (32'(offset) >= 32'(lmlt_pkg::HBLANK_START)) begin
      mode = lmlt_pkg::MODE_HBLANK;
    end else if (32'(offset) >= 32'(lmlt_pkg::XFER_START)) begin
      mode = lmlt_pkg::MODE_XFER;
    end else begin
      mode = lmlt_pkg::MODE_OAM;
    end
  end

  // Line zero counts as new once the last visible line has been rendered.
  assign render_hit = ((rendered_line < line_now) ||
                       ((line_now == '0) &&
                        (rendered_line >= lmlt_pkg::LINE_W'(VISIBLE_LINES - 1)))) &&
                      (line_now < lmlt_pkg::LINE_W'(VISIBLE_LINES)) &&
                      (32'(offset) > 32'(lmlt_pkg::RENDER_AFTER));

  always_comb begin
    rendered_line_next    = render_hit ? line_now : rendered_line;
    last_line_next        = last_line;
    coincidence_flag_next = coincidence_flag;
    result.stat_irq       = 1'b0;
    result.vblank_irq     = 1'b0;
    if (line_now != last_line) begin
      last_line_next        = line_now;
      coincidence_flag_next = (line_now == line_compare);
      result.stat_irq       = (line_now == line_compare) && coincidence_irq_enable;
      result.vblank_irq     = (line_now == lmlt_pkg::LINE_W'(VISIBLE_LINES));
    end
    result.lcd_mode     = mode;
    result.current_line = line_now;
    result.coincidence  = coincidence_flag_next;
    result.render_line  = render_hit;
  end

endmodule

FILE: src/lcd_mode_and_line_timing_core.sv
// Top level of the LCD mode and line timing block.
//
//   channel | signals                          | transfer rule
//   in      | in_valid, in_ready, cycles       | valid and ready high at clk
//   out     | out_valid, out_ready, lcd_mode.. | valid and ready high at clk
//   cfg     | cfg_we, cfg_index, cfg_data      | write when cfg_we high at clk
//
// One transaction enters every cycle unless input is held off; its result is
// registered. The frame, line and offset counters update in the same cycle,
// set by the 17-bit position add with wrap, then the line boundary subtraction.
// While out_valid is high and out_ready is low, input is held off.
// rst (synchronous) clears all counters, flags and configuration registers.
`include "lcd_mode_and_line_timing_core_macros.svh"

module lcd_mode_and_line_timing_core #(
  parameter int LINE_CYCLES   = lmlt_pkg::LINE_CYCLES_DEFAULT,
  parameter int FRAME_CYCLES  = lmlt_pkg::FRAME_CYCLES_DEFAULT,
  parameter int VBLANK_START  = lmlt_pkg::VBLANK_START_DEFAULT,
  parameter int VISIBLE_LINES = lmlt_pkg::VISIBLE_LINES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lmlt_pkg::CYCLES_W-1:0]    cycles,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       lcd_mode,
  output logic [lmlt_pkg::LINE_W-1:0]      current_line,
  output logic                             coincidence,
  output logic                             render_line,
  output logic                             stat_irq,
  output logic                             vblank_irq,
  input  logic                             cfg_we,
  input  logic [lmlt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lmlt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int FP_W   = $clog2(FRAME_CYCLES);
  localparam int INTO_W = $clog2(LINE_CYCLES);

  logic [lmlt_pkg::LINE_W-1:0] line_compare;
  logic                        coincidence_irq_enable;

  logic [FP_W-1:0]             frame_position;
  logic [INTO_W-1:0]           line_offset;
  logic [lmlt_pkg::LINE_W-1:0] rendered_line;
  logic [lmlt_pkg::LINE_W-1:0] last_line;
  logic                        coincidence_flag;

  logic [FP_W-1:0]             frame_position_next;
  logic [INTO_W-1:0]           line_offset_next;
  logic [lmlt_pkg::LINE_W-1:0] rendered_line_next;
  logic [lmlt_pkg::LINE_W-1:0] last_line_next;
  logic                        coincidence_flag_next;
  lmlt_pkg::lmlt_result_t      result_next;
  lmlt_pkg::lmlt_result_t      result;

  logic                        in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_compare           <= '0;
      coincidence_irq_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        lmlt_pkg::REG_LINE_COMPARE: line_compare <= cfg_data;
        lmlt_pkg::REG_IRQ_ENABLE:   coincidence_irq_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lmlt_step #(
    .LINE_CYCLES  (LINE_CYCLES),
    .FRAME_CYCLES (FRAME_CYCLES),
    .VBLANK_START (VBLANK_START),
    .VISIBLE_LINES(VISIBLE_LINES)
  ) u_step (
    .cycles                (cycles),
    .frame_position        (frame_position),
    .line_offset           (line_offset),
    .line                  (result.current_line),
    .rendered_line         (rendered_line),
    .last_line             (last_line),
    .coincidence_flag      (coincidence_flag),
    .line_compare          (line_compare),
    .coincidence_irq_enable(coincidence_irq_enable),
    .frame_position_next   (frame_position_next),
    .line_offset_next      (line_offset_next),
    .rendered_line_next    (rendered_line_next),
    .last_line_next        (last_line_next),
    .coincidence_flag_next (coincidence_flag_next),
    .result                (result_next)
  );

  // The result register also holds the current line for the next transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position   <= '0;
      line_offset      <= '0;
      rendered_line    <= '0;
      last_line        <= '0;
      coincidence_flag <= 1'b0;
      result           <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (in_fire) begin
        frame_position   <= frame_position_next;
        line_offset      <= line_offset_next;
        rendered_line    <= rendered_line_next;
        last_line        <= last_line_next;
        coincidence_flag <= coincidence_flag_next;
        result           <= result_next;
        out_valid        <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign lcd_mode     = result.lcd_mode;
  assign current_line = result.current_line;
  assign coincidence  = result.coincidence;
  assign render_line  = result.render_line;
  assign stat_irq     = result.stat_irq;
  assign vblank_irq   = result.vblank_irq;

  `LMLT_ASSERT_IMP(a_offset_in_line, 1'b1, 32'(line_offset) < 32'(LINE_CYCLES),
                   "line offset reached the line length")
  `LMLT_ASSERT_IMP(a_position_in_frame, 1'b1,
                   32'(frame_position) < 32'(FRAME_CYCLES),
                   "frame position reached the frame length")
  `LMLT_ASSERT_IMP(a_vblank_line, out_valid && vblank_irq,
                   current_line == lmlt_pkg::LINE_W'(VISIBLE_LINES),
                   "vblank interrupt away from the first vblank line")
  `LMLT_ASSERT_IMP(a_stat_needs_match, out_valid && stat_irq,
                   coincidence && (current_line == last_line),
                   "status interrupt without a line match")
  `LMLT_ASSERT_IMP(a_render_visible, out_valid && render_line,
                   (current_line < lmlt_pkg::LINE_W'(VISIBLE_LINES)) &&
                   (rendered_line == current_line),
                   "render strobe outside the visible lines")

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the LCD mode and line timing core.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_STALL  = 60;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 160;
  localparam int FRAME_LINES = lmlt_pkg::FRAME_CYCLES_DEFAULT / lmlt_pkg::LINE_CYCLES_DEFAULT;

  typedef struct packed {
    logic [lmlt_pkg::CYCLES_W-1:0] cyc;
    logic                          known;
    lmlt_pkg::lmlt_result_t        res;
  } timing_row_t;

  localparam lmlt_pkg::lmlt_result_t NO_RESULT = '0;

  // Walk from reset through every mode of line 0, the render strobe threshold
  // of line 1 and a line-compare hit on line 2.
  localparam int DIRECTED_ROWS = 16;
  localparam timing_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{8'd0,   1'b1, '{lmlt_pkg::MODE_OAM,    8'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{8'd255, 1'b1, '{lmlt_pkg::MODE_XFER,   8'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{8'd101, 1'b1, '{lmlt_pkg::MODE_HBLANK, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{8'd99,  1'b0, NO_RESULT},
    '{8'd1,   1'b0, NO_RESULT},
    '{8'd79,  1'b0, NO_RESULT},
    '{8'd1,   1'b0, NO_RESULT},
    '{8'd3,   1'b0, NO_RESULT},
    '{8'd1,   1'b0, NO_RESULT},
    '{8'd255, 1'b0, NO_RESULT},
    '{8'd16,  1'b0, NO_RESULT},
    '{8'd1,   1'b0, NO_RESULT},
    '{8'd100, 1'b0, NO_RESULT},
    '{8'd200, 1'b0, NO_RESULT},
    '{8'd255, 1'b0, NO_RESULT},
    '{8'd1,   1'b0, NO_RESULT}
  };

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [lmlt_pkg::CYCLES_W-1:0]    cycles = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [1:0]                       lcd_mode;
  logic [lmlt_pkg::LINE_W-1:0]      current_line;
  logic                             coincidence;
  logic                             render_line;
  logic                             stat_irq;
  logic                             vblank_irq;
  logic                             cfg_we = 1'b0;
  logic [lmlt_pkg::CFG_INDEX_W-1:0] cfg_index = lmlt_pkg::REG_LINE_COMPARE;
  logic [lmlt_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // Typed-in expectation that travels with the transaction on the input port.
  logic                   row_known = 1'b0;
  lmlt_pkg::lmlt_result_t row_result = '0;

  // Timing model state and its copy of the registers.
  logic [16:0]                 frame_pos = '0;
  int unsigned                 drawn_line = 0;
  int unsigned                 prev_line = 0;
  logic                        match_flag = 1'b0;
  logic [lmlt_pkg::LINE_W-1:0] cmp_line = '0;
  logic                        cmp_irq_en = 1'b0;

  lmlt_pkg::lmlt_result_t expected_timing[$];

  int   errors = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   stall_left = 0;
  int   cycle_count = 0;
  logic long_stall_go = 1'b0;

  lcd_mode_and_line_timing_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cycles       (cycles),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .lcd_mode     (lcd_mode),
    .current_line (current_line),
    .coincidence  (coincidence),
    .render_line  (render_line),
    .stat_irq     (stat_irq),
    .vblank_irq   (vblank_irq),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic lmlt_pkg::lmlt_result_t advance_timing(
      input logic [lmlt_pkg::CYCLES_W-1:0] c);
    int unsigned pos;
    int unsigned into;
    int unsigned line;
    lmlt_pkg::lmlt_result_t r;
    pos  = (int'(frame_pos) + int'(c)) % lmlt_pkg::FRAME_CYCLES_DEFAULT;
    into = pos % lmlt_pkg::LINE_CYCLES_DEFAULT;
    line = (pos / lmlt_pkg::LINE_CYCLES_DEFAULT) & 8'hff;
    r = '0;
    frame_pos = pos[16:0];
    if (pos >= lmlt_pkg::VBLANK_START_DEFAULT) begin
      r.lcd_mode = lmlt_pkg::MODE_VBLANK;
    end else if (into >= lmlt_pkg::HBLANK_START) begin
      r.lcd_mode = lmlt_pkg::MODE_HBLANK;
    end else if (into >= lmlt_pkg::XFER_START) begin
      r.lcd_mode = lmlt_pkg::MODE_XFER;
    end else begin
      r.lcd_mode = lmlt_pkg::MODE_OAM;
    end
    // Line 0 counts as new again once the last visible line was drawn.
    if ((drawn_line < line ||
         (line == 0 && drawn_line >= lmlt_pkg::VISIBLE_LINES_DEFAULT - 1)) &&
        line < lmlt_pkg::VISIBLE_LINES_DEFAULT && into > lmlt_pkg::RENDER_AFTER) begin
      drawn_line = line;
      r.render_line = 1'b1;
    end
    if (line != prev_line) begin
      prev_line = line;
      match_flag = (line == cmp_line);
      r.stat_irq = match_flag && cmp_irq_en;
      r.vblank_irq = (line == lmlt_pkg::VISIBLE_LINES_DEFAULT);
    end
    r.current_line = line[lmlt_pkg::LINE_W-1:0];
    r.coincidence = match_flag;
    return r;
  endfunction

  // Register writes, input and output transactions, all seen at the clock edge.
  always @(posedge clk) begin
    lmlt_pkg::lmlt_result_t exp_r;
    lmlt_pkg::lmlt_result_t got_r;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          lmlt_pkg::REG_LINE_COMPARE: cmp_line = cfg_data;
          lmlt_pkg::REG_IRQ_ENABLE:   cmp_irq_en = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        exp_r = advance_timing(cycles);
        expected_timing.push_back(row_known ? row_result : exp_r);
      end
      if (out_valid && out_ready) begin
        got_r = '{lcd_mode, current_line, coincidence, render_line, stat_irq, vblank_irq};
        if (expected_timing.size() == 0) begin
          $error("result transaction arrived with none expected");
          errors++;
        end else begin
          exp_r = expected_timing.pop_front();
          if (got_r.lcd_mode !== exp_r.lcd_mode) begin
            $error("lcd_mode: expected %0d, got %0d", exp_r.lcd_mode, got_r.lcd_mode);
            errors++;
          end
          if (got_r.current_line !== exp_r.current_line) begin
            $error("current_line: expected %0d, got %0d",
                   exp_r.current_line, got_r.current_line);
            errors++;
          end
          if (got_r.coincidence !== exp_r.coincidence) begin
            $error("coincidence: expected %0b, got %0b",
                   exp_r.coincidence, got_r.coincidence);
            errors++;
          end
          if (got_r.render_line !== exp_r.render_line) begin
            $error("render_line: expected %0b, got %0b",
                   exp_r.render_line, got_r.render_line);
            errors++;
          end
          if (got_r.stat_irq !== exp_r.stat_irq) begin
            $error("stat_irq: expected %0b, got %0b", exp_r.stat_irq, got_r.stat_irq);
            errors++;
          end
          if (got_r.vblank_irq !== exp_r.vblank_irq) begin
            $error("vblank_irq: expected %0b, got %0b",
                   exp_r.vblank_irq, got_r.vblank_irq);
            errors++;
          end
        end
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  always @(posedge clk) begin
    if (long_stall_go) begin
      long_stall_go <= 1'b0;
      stall_left = LONG_STALL;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_regs(input logic [lmlt_pkg::LINE_W-1:0] line_val,
                            input logic irq_en);
    cfg_we    <= 1'b1;
    cfg_index <= lmlt_pkg::REG_LINE_COMPARE;
    cfg_data  <= line_val;
    @(posedge clk);
    cfg_index <= lmlt_pkg::REG_IRQ_ENABLE;
    cfg_data  <= {{(lmlt_pkg::CFG_DATA_W-1){1'b0}}, irq_en};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_cycles(input logic [lmlt_pkg::CYCLES_W-1:0] c, input logic known,
                             input lmlt_pkg::lmlt_result_t res);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cycles     <= c;
    row_known  <= known;
    row_result <= res;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_timing.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  initial begin
    logic [lmlt_pkg::CYCLES_W-1:0] c;
    logic [lmlt_pkg::LINE_W-1:0]   line_val;
    logic                          irq_en;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_regs(8'd2, 1'b1);
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_cycles(DIRECTED[i].cyc, DIRECTED[i].known, DIRECTED[i].res);
    end
    drain_results();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 84; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 84; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      // Extremes and the first and last vblank lines first, then compare lines placed just ahead of the beam.
      case (ph)
        0:       line_val = 8'd0;
        1:       line_val = 8'd255;
        2:       line_val = 8'd144;
        3:       line_val = 8'd153;
        default: line_val = lmlt_pkg::LINE_W'((prev_line + $urandom_range(1, 20)) %
                                              FRAME_LINES);
      endcase
      irq_en = (ph != 3 && ph != 6);
      write_regs(line_val, irq_en);
      // With no sender gaps, a long receiver hold-off backs up the input.
      if (ph == 0) long_stall_go <= 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == PHASE_ITEMS / 2) drain_results();
        case ($urandom_range(3))
          0:       c = 8'hff;
          1:       c = lmlt_pkg::CYCLES_W'($urandom_range(7));
          default: c = lmlt_pkg::CYCLES_W'($urandom_range(255));
        endcase
        send_cycles(c, 1'b0, NO_RESULT);
      end
      drain_results();
    end

    repeat (4) @(posedge clk);
    if (expected_timing.size() != 0) begin
      $error("%0d expected results never arrived", expected_timing.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
